// File: rtl/core/dppdr_pkg.sv
// ----------------------------------------------------------------------------
// dppdr_pkg
// Shared constants and widths for the dual PID duty regulator.
// ----------------------------------------------------------------------------
package dppdr_pkg;

  localparam int HISTORY_DEPTH = 4;

  localparam int IN_W    = 10;
  localparam int GAIN_W  = 10;
  localparam int DUTY_W  = 16;
  localparam int ERR_W   = IN_W + 1;
  localparam int SUM_W   = ERR_W + $clog2(HISTORY_DEPTH);
  localparam int PROD_W  = SUM_W + GAIN_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam int S_TDATA_W = 4 * IN_W;
  localparam int M_TDATA_W = ((2 * (DUTY_W + 1) + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = DUTY_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP      = 3'd4;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 10'd10;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 10'd1;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = 10'd2;
  localparam logic [GAIN_W-1:0] GAIN_DIVISOR_RST = 10'd100;
  localparam logic [DUTY_W-1:0] PWM_TOP_RST      = 16'd9999;

endpackage

// File: rtl/core/dual_pid_pwm_duty_regulator_top.sv
// ----------------------------------------------------------------------------
// dual_pid_pwm_duty_regulator_top
// Two-channel incremental PID duty regulator with windowed integral term.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per control update: target and measured current
//   for channels A and B. m_axis returns one word per update with both new
//   duties and drive enables. Write gains, divisor and pwm_top over the cfg
//   port only while the block is idle; the block itself does not enforce this.
//   Both channels share one multiplier and one restoring divider (one
//   quotient bit per cycle, PROD_W bits, with PROD_W = 23 for history depth
//   4). An inactive channel only passes through LOAD; an active one runs
//   LOAD, then MUL, DIV and ACC for each of the P, I and D terms, then CLAMP.
//   s_axis_tready returns when the update leaves DONE for IDLE, so no new
//   word is accepted before the current update is through.
//   Both channels run back to back through the divider, so the divider loop
//   sets the rate.
//   The result sits in an output register; a new word is accepted while it
//   waits, and a stalled receiver holds the sequencer only at the end of the
//   next update. Reset clears histories and duties and loads default gains.
// ----------------------------------------------------------------------------
module dual_pid_pwm_duty_regulator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // target_a, measured_a, target_b, measured_b
  input  logic [dppdr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // duty_a, drive_a_on, duty_b, drive_b_on, zero fill
  output logic [dppdr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [dppdr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dppdr_pkg::CFG_DAT_W-1:0]  cfg_wdata_i
);
  import dppdr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_CLAMP = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  logic [2:0] state_q, state_d;
  logic       ch_q, ch_d;
  logic [1:0] term_q, term_d;

  logic [GAIN_W-1:0] kp_q, kp_d, ki_q, ki_d, kd_q, kd_d, div_q, div_d;
  logic [DUTY_W-1:0] top_q, top_d;

  logic [S_TDATA_W-1:0] in_q, in_d;

  logic signed [ERR_W-1:0] err_q [2][HISTORY_DEPTH];
  logic signed [ERR_W-1:0] err_d [2][HISTORY_DEPTH];
  logic signed [SUM_W-1:0] wsum_q [2];
  logic signed [SUM_W-1:0] wsum_d [2];
  logic [DUTY_W-1:0]       duty_q [2];
  logic [DUTY_W-1:0]       duty_d [2];

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0]       mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [GAIN_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic                    out_vld_q, out_vld_d;
  logic [M_TDATA_W-1:0]    out_q, out_d;

  // datapath helpers
  logic [IN_W-1:0]           tgt, meas;
  logic signed [ERR_W-1:0]   err_new;
  logic [GAIN_W-1:0]         den, gain;
  logic signed [SUM_W-1:0]   op;
  logic signed [SUM_W+GAIN_W:0] mul_full;
  logic signed [PROD_W-1:0]  prod;
  logic [GAIN_W:0]           trial;
  logic                      qbit;
  logic signed [ACC_W-1:0]   quot;
  logic signed [ACC_W-1:0]   top_ext;
  logic                      out_free;

  assign tgt  = ch_q ? in_q[3*IN_W-1:2*IN_W] : in_q[IN_W-1:0];
  assign meas = ch_q ? in_q[4*IN_W-1:3*IN_W] : in_q[2*IN_W-1:IN_W];
  assign err_new = $signed({1'b0, tgt}) - $signed({1'b0, meas});
  assign den = (div_q == '0) ? GAIN_W'(1) : div_q;

  always_comb begin
    unique case (term_q)
      TERM_P: begin
        gain = kp_q;
        op   = SUM_W'(err_q[ch_q][0]);
      end
      TERM_I: begin
        gain = ki_q;
        op   = wsum_q[ch_q];
      end
      default: begin
        gain = kd_q;
        op   = SUM_W'(err_q[ch_q][0]) - SUM_W'(err_q[ch_q][1]);
      end
    endcase
  end

  assign mul_full = $signed({1'b0, gain}) * op;
  assign prod     = mul_full[PROD_W-1:0];
  assign trial    = {rem_q, mag_q[PROD_W-1]};
  assign qbit     = (trial >= {1'b0, den});
  assign quot     = neg_q ? -$signed({3'b000, mag_q}) : $signed({3'b000, mag_q});
  assign top_ext  = $signed({{(ACC_W-DUTY_W){1'b0}}, top_q});
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    term_d    = term_q;
    kp_d      = kp_q;
    ki_d      = ki_q;
    kd_d      = kd_q;
    div_d     = div_q;
    top_d     = top_q;
    in_d      = in_q;
    err_d     = err_q;
    wsum_d    = wsum_q;
    duty_d    = duty_q;
    acc_d     = acc_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:    kp_d  = cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_GAIN:   ki_d  = cfg_wdata_i[GAIN_W-1:0];
        REG_DERIV_GAIN:   kd_d  = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_DIVISOR: div_d = cfg_wdata_i[GAIN_W-1:0];
        REG_PWM_TOP:      top_d = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          in_d    = s_axis_tdata;
          ch_d    = 1'b0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (tgt == '0) begin
          duty_d[ch_q] = '0;
          if (ch_q) begin
            state_d = ST_DONE;
          end else begin
            ch_d = 1'b1;
          end
        end else begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            err_d[ch_q][i] = err_q[ch_q][i-1];
          end
          err_d[ch_q][0] = err_new;
          wsum_d[ch_q]   = wsum_q[ch_q] + SUM_W'(err_new)
                           - SUM_W'(err_q[ch_q][HISTORY_DEPTH-1]);
          acc_d   = $signed({{(ACC_W-DUTY_W){1'b0}}, duty_q[ch_q]});
          term_d  = TERM_P;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        neg_d   = prod[PROD_W-1];
        mag_d   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        rem_d   = '0;
        cnt_d   = CNT_W'(PROD_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = qbit ? GAIN_W'(trial - {1'b0, den}) : trial[GAIN_W-1:0];
        mag_d = {mag_q[PROD_W-2:0], qbit};
        if (cnt_q == '0) begin
          state_d = ST_ACC;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_ACC: begin
        acc_d = acc_q + quot;
        if (term_q == TERM_D) begin
          state_d = ST_CLAMP;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_CLAMP: begin
        priority if (acc_q < 0) begin
          duty_d[ch_q] = '0;
        end else if (acc_q > top_ext) begin
          duty_d[ch_q] = top_q;
        end else begin
          duty_d[ch_q] = acc_q[DUTY_W-1:0];
        end
        if (ch_q) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d = M_TDATA_W'({duty_q[1] != '0, duty_q[1], duty_q[0] != '0, duty_q[0]});
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= 1'b0;
      term_q    <= TERM_P;
      kp_q      <= PROP_GAIN_RST;
      ki_q      <= INTEG_GAIN_RST;
      kd_q      <= DERIV_GAIN_RST;
      div_q     <= GAIN_DIVISOR_RST;
      top_q     <= PWM_TOP_RST;
      out_vld_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        wsum_q[c] <= '0;
        duty_q[c] <= '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          err_q[c][i] <= '0;
        end
      end
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      term_q    <= term_d;
      kp_q      <= kp_d;
      ki_q      <= ki_d;
      kd_q      <= kd_d;
      div_q     <= div_d;
      top_q     <= top_d;
      out_vld_q <= out_vld_d;
      wsum_q    <= wsum_d;
      duty_q    <= duty_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    acc_q <= acc_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_LOAD && !ch_q)
    else $error("accepted word did not start channel A");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < den)
    else $error("divider remainder out of range");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DUTY_W-1:0] <= top_q
                      && m_axis_tdata[2*DUTY_W:DUTY_W+1] <= top_q)
    else $error("output duty above pwm_top");

  a_drive_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DUTY_W] == (m_axis_tdata[DUTY_W-1:0] != '0)
                      && m_axis_tdata[2*DUTY_W+1] ==
                         (m_axis_tdata[2*DUTY_W:DUTY_W+1] != '0))
    else $error("drive enable does not match duty");
`endif

endmodule
